[sv/bpc_pkg.sv]
`timescale 1ns / 1ps
// Types, constants and small helpers for the barometric compensation block.
// No dependencies; every other file imports this package.
package bpc_pkg;

    localparam int RAW_W   = 19;
    localparam int CFG_IDX_W = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_AC1_AC2 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AC3_AC4 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AC5_AC6 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_B1_B2   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MC_MD   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OSS     = 3'd5;

    // item kinds
    localparam logic OP_TEMP  = 1'b0;
    localparam logic OP_PRESS = 1'b1;

    // compensation constants
    localparam logic [31:0] C_B6_BIAS  = 32'd4000;
    localparam logic [31:0] C_B4_BIAS  = 32'd32768;
    localparam logic [31:0] C_T_ROUND  = 32'd8;
    localparam logic [31:0] C_B_ROUND  = 32'd2;
    localparam logic [31:0] C_P_K1     = 32'd3038;
    localparam logic [31:0] C_P_K2     = 32'hFFFF_E343;   // -7357
    localparam logic [31:0] C_P_K3     = 32'd3791;

    typedef enum logic {
        ALU_ADD,
        ALU_MUL
    } alu_op_t;

    // shared unit control: y = shr(op == MUL ? a*b : (a << lsh) +/- b, rsh)
    typedef struct packed {
        alu_op_t    op;
        logic       sub;
        logic [1:0] lsh;
        logic [4:0] rsh;
        logic       arith;
    } alu_ctl_t;

    typedef enum logic [5:0] {
        S_IDLE,
        T_DIFF, T_X1, T_DEN, T_ABSDEN, T_ABSNUM, T_DIVGO, T_DIVWAIT, T_B5, T_OUT,
        P_B6, P_SQ, P_X1A, P_X2A, P_X3A, P_AC1, P_B3,
        P_X1B, P_X2B, P_SUMB, P_X3B, P_OFF, P_B4,
        P_DIFF, P_B7, P_DIVGO, P_DIVWAIT,
        P_PSH, P_SQP, P_X1C, P_X2C, P_SUMC, P_RND, P_OUT,
        S_FAIL
    } state_t;

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] zx16(input logic [15:0] v);
        return {16'd0, v};
    endfunction

    // 50000 >> oss
    function automatic logic [31:0] b7_scale(input logic [1:0] oss);
        logic [31:0] s;
        unique case (oss)
            2'd0: s = 32'd50000;
            2'd1: s = 32'd25000;
            2'd2: s = 32'd12500;
            2'd3: s = 32'd6250;
        endcase
        return s;
    endfunction

endpackage

[sv/bpc_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces: raw samples in, compensated results out,
// and the configuration write channel. Depends on bpc_pkg.
interface bpc_in_if;
    import bpc_pkg::*;
    logic             valid;
    logic             ready;
    logic             op;
    logic [RAW_W-1:0] raw_value;

    modport source (output valid, output op, output raw_value, input ready);
    modport sink   (input valid, input op, input raw_value, output ready);
endinterface

interface bpc_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;
    logic               kind;
    logic               status;

    modport source (output valid, output value, output kind, output status, input ready);
    modport sink   (input valid, input value, input kind, input status, output ready);
endinterface

interface bpc_cfg_if;
    import bpc_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [31:0]          data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/bpc_alu.sv]
`timescale 1ns / 1ps
// Shared arithmetic unit: 32x32 low-half multiply or shifted add/subtract,
// followed by a right shift. Depends on bpc_pkg.
module bpc_alu
    import bpc_pkg::*;
(
    input  alu_ctl_t    ctl,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] y
);

    logic [31:0] prod;
    logic [31:0] shl_a;
    logic [31:0] addend;
    logic [31:0] sum;
    logic [31:0] pre;

    assign prod   = a * b;
    assign shl_a  = a << ctl.lsh;
    assign addend = ctl.sub ? ~b : b;
    assign sum    = shl_a + addend + {31'd0, ctl.sub};

    always_comb
    begin
        unique case (ctl.op)
            ALU_MUL: pre = prod;
            ALU_ADD: pre = sum;
        endcase
        if (ctl.arith)
            y = 32'($signed(pre) >>> ctl.rsh);
        else
            y = pre >> ctl.rsh;
    end

endmodule

[sv/bpc_div.sv]
`timescale 1ns / 1ps
// Unsigned 32/32 restoring divider, one quotient bit per cycle.
// Depends on bpc_pkg only for the common import style.
module bpc_div
    import bpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [32:0] rem_shift;
    logic [32:0] trial;

    assign rem_shift = {rem_reg, quo_reg[31]};
    assign trial     = rem_shift - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 5'd0;
            quo_next  = dividend;
            rem_next  = 32'd0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial[32])
            begin
                rem_next = rem_shift[31:0];
                quo_next = {quo_reg[30:0], 1'b0};
            end
            else
            begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[sv/barometric_pressure_compensation_top.sv]
`timescale 1ns / 1ps
// Top level: configuration registers, step sequencer and result register.
// Depends on bpc_pkg, bpc_if, bpc_alu and bpc_div.

// Integer barometer compensation. One sample beat at a time: the block drops
// sample.ready from acceptance until the result has been placed in the output
// register, which may still be waiting for result.ready while the next sample
// is taken. Each beat runs through the divider, which yields one quotient bit
// per cycle, and through a chain of steps on the shared multiply/add unit.
// A zero divisor ends the item early with status 1 and value 0. The
// temperature term is kept between items and reads 0 after reset.
// Configuration writes are always accepted and belong in idle periods.
module barometric_pressure_compensation_top
    import bpc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    bpc_in_if.sink    sample,
    bpc_out_if.source result,
    bpc_cfg_if.sink   cfg
);

    // configuration
    logic [31:0] ac12_reg, ac34_reg, ac56_reg, b12_reg, mcmd_reg;
    logic [1:0]  oss_reg;

    // sequencer and working registers
    state_t      state_reg, state_next;
    logic        op_reg, op_next;
    logic [RAW_W-1:0] raw_reg, raw_next;
    logic        neg_reg, neg_next;
    logic [31:0] b5_reg, b5_next;
    logic [31:0] x1_reg, x1_next;
    logic [31:0] t1_reg, t1_next;
    logic [31:0] t2_reg, t2_next;
    logic [31:0] b6_reg, b6_next;
    logic [31:0] sq_reg, sq_next;
    logic [31:0] b3_reg, b3_next;
    logic [31:0] b4_reg, b4_next;
    logic [31:0] b7_reg, b7_next;
    logic [31:0] p_reg, p_next;

    // output register
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_value_reg, out_value_next;
    logic        out_kind_reg, out_kind_next;
    logic        out_status_reg, out_status_next;

    alu_ctl_t    ctl;
    logic [31:0] alu_a, alu_b, alu_y;
    logic        div_start, div_done;
    logic [31:0] div_dividend, div_divisor, div_q;
    logic        emit_req, emit_status, can_emit;
    logic [31:0] emit_value;

    bpc_alu u_alu (
        .ctl (ctl),
        .a   (alu_a),
        .b   (alu_b),
        .y   (alu_y)
    );

    bpc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    assign sample.ready = (state_reg == S_IDLE);
    assign cfg.ready    = 1'b1;
    assign can_emit     = !out_valid_reg || result.ready;

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        raw_next     = raw_reg;
        neg_next     = neg_reg;
        b5_next      = b5_reg;
        x1_next      = x1_reg;
        t1_next      = t1_reg;
        t2_next      = t2_reg;
        b6_next      = b6_reg;
        sq_next      = sq_reg;
        b3_next      = b3_reg;
        b4_next      = b4_reg;
        b7_next      = b7_reg;
        p_next       = p_reg;
        ctl          = '{op: ALU_ADD, sub: 1'b0, lsh: 2'd0, rsh: 5'd0, arith: 1'b1};
        alu_a        = 32'd0;
        alu_b        = 32'd0;
        div_start    = 1'b0;
        div_dividend = t2_reg;
        div_divisor  = t1_reg;
        emit_req     = 1'b0;
        emit_status  = 1'b0;
        emit_value   = alu_y;

        unique case (state_reg)
            S_IDLE:
            begin
                if (sample.valid)
                begin
                    op_next    = sample.op;
                    raw_next   = sample.raw_value;
                    state_next = (sample.op == OP_PRESS) ? P_B6 : T_DIFF;
                end
            end
            // ---- temperature ----
            T_DIFF:
            begin
                alu_a = zx16(raw_reg[15:0]);
                alu_b = zx16(ac56_reg[15:0]);
                ctl.sub = 1'b1;
                t1_next = alu_y;
                state_next = T_X1;
            end
            T_X1:
            begin
                alu_a = t1_reg;
                alu_b = zx16(ac56_reg[31:16]);
                ctl.op = ALU_MUL;
                ctl.rsh = 5'd15;
                x1_next = alu_y;
                state_next = T_DEN;
            end
            T_DEN:
            begin
                alu_a = x1_reg;
                alu_b = sx16(mcmd_reg[15:0]);
                t2_next = alu_y;
                state_next = T_ABSDEN;
            end
            T_ABSDEN:
            begin
                alu_b = t2_reg;
                ctl.sub = t2_reg[31];
                t1_next = alu_y;
                neg_next = t2_reg[31] ^ mcmd_reg[31];
                state_next = (t2_reg == 32'd0) ? S_FAIL : T_ABSNUM;
            end
            T_ABSNUM:
            begin
                // MC * 2048, then its magnitude
                alu_b = {{5{mcmd_reg[31]}}, mcmd_reg[31:16], 11'd0};
                ctl.sub = mcmd_reg[31];
                t2_next = alu_y;
                state_next = T_DIVGO;
            end
            T_DIVGO:
            begin
                div_start = 1'b1;
                state_next = T_DIVWAIT;
            end
            T_DIVWAIT:
            begin
                alu_b = div_q;
                ctl.sub = neg_reg;
                if (div_done)
                begin
                    t1_next = alu_y;
                    state_next = T_B5;
                end
            end
            T_B5:
            begin
                alu_a = x1_reg;
                alu_b = t1_reg;
                b5_next = alu_y;
                state_next = T_OUT;
            end
            T_OUT:
            begin
                alu_a = b5_reg;
                alu_b = C_T_ROUND;
                ctl.rsh = 5'd4;
                emit_req = 1'b1;
                if (can_emit)
                    state_next = S_IDLE;
            end
            // ---- pressure: B3 ----
            P_B6:
            begin
                alu_a = b5_reg;
                alu_b = C_B6_BIAS;
                ctl.sub = 1'b1;
                b6_next = alu_y;
                state_next = P_SQ;
            end
            P_SQ:
            begin
                alu_a = b6_reg;
                alu_b = b6_reg;
                ctl.op = ALU_MUL;
                ctl.rsh = 5'd12;
                sq_next = alu_y;
                state_next = P_X1A;
            end
            P_X1A:
            begin
                alu_a = sx16(b12_reg[15:0]);
                alu_b = sq_reg;
                ctl.op = ALU_MUL;
                ctl.rsh = 5'd11;
                t1_next = alu_y;
                state_next = P_X2A;
            end
            P_X2A:
            begin
                alu_a = sx16(ac12_reg[15:0]);
                alu_b = b6_reg;
                ctl.op = ALU_MUL;
                ctl.rsh = 5'd11;
                t2_next = alu_y;
                state_next = P_X3A;
            end
            P_X3A:
            begin
                alu_a = t1_reg;
                alu_b = t2_reg;
                t1_next = alu_y;
                state_next = P_AC1;
            end
            P_AC1:
            begin
                alu_a = sx16(ac12_reg[31:16]);
                alu_b = t1_reg;
                ctl.lsh = 2'd2;
                t1_next = alu_y;
                state_next = P_B3;
            end
            P_B3:
            begin
                alu_a = t1_reg;
                alu_b = C_B_ROUND;
                ctl.lsh = oss_reg;
                ctl.rsh = 5'd2;
                b3_next = alu_y;
                state_next = P_X1B;
            end
            // ---- pressure: B4 ----
            P_X1B:
            begin
                alu_a = sx16(ac34_reg[31:16]);
                alu_b = b6_reg;
                ctl.op = ALU_MUL;
                ctl.rsh = 5'd13;
                t1_next = alu_y;
                state_next = P_X2B;
            end
            P_X2B:
            begin
                alu_a = sx16(b12_reg[31:16]);
                alu_b = sq_reg;
                ctl.op = ALU_MUL;
                ctl.rsh = 5'd16;
                t2_next = alu_y;
                state_next = P_SUMB;
            end
            P_SUMB:
            begin
                alu_a = t1_reg;
                alu_b = t2_reg;
                t1_next = alu_y;
                state_next = P_X3B;
            end
            P_X3B:
            begin
                alu_a = t1_reg;
                alu_b = C_B_ROUND;
                ctl.rsh = 5'd2;
                t1_next = alu_y;
                state_next = P_OFF;
            end
            P_OFF:
            begin
                alu_a = t1_reg;
                alu_b = C_B4_BIAS;
                t1_next = alu_y;
                state_next = P_B4;
            end
            P_B4:
            begin
                alu_a = zx16(ac34_reg[15:0]);
                alu_b = t1_reg;
                ctl.op = ALU_MUL;
                ctl.rsh = 5'd15;
                ctl.arith = 1'b0;
                b4_next = alu_y;
                state_next = P_DIFF;
            end
            // ---- pressure: B7 and division ----
            P_DIFF:
            begin
                alu_a = {{(32-RAW_W){1'b0}}, raw_reg};
                alu_b = b3_reg;
                ctl.sub = 1'b1;
                t1_next = alu_y;
                state_next = P_B7;
            end
            P_B7:
            begin
                alu_a = t1_reg;
                alu_b = b7_scale(oss_reg);
                ctl.op = ALU_MUL;
                b7_next = alu_y;
                state_next = P_DIVGO;
            end
            P_DIVGO:
            begin
                div_dividend = b7_reg[31] ? b7_reg : {b7_reg[30:0], 1'b0};
                div_divisor  = b4_reg;
                if (b4_reg == 32'd0)
                    state_next = S_FAIL;
                else
                begin
                    div_start = 1'b1;
                    state_next = P_DIVWAIT;
                end
            end
            P_DIVWAIT:
            begin
                if (div_done)
                begin
                    p_next = b7_reg[31] ? {div_q[30:0], 1'b0} : div_q;
                    state_next = P_PSH;
                end
            end
            // ---- pressure: final correction ----
            P_PSH:
            begin
                alu_a = p_reg;
                ctl.rsh = 5'd8;
                t1_next = alu_y;
                state_next = P_SQP;
            end
            P_SQP:
            begin
                alu_a = t1_reg;
                alu_b = t1_reg;
                ctl.op = ALU_MUL;
                t1_next = alu_y;
                state_next = P_X1C;
            end
            P_X1C:
            begin
                alu_a = t1_reg;
                alu_b = C_P_K1;
                ctl.op = ALU_MUL;
                ctl.rsh = 5'd16;
                t1_next = alu_y;
                state_next = P_X2C;
            end
            P_X2C:
            begin
                alu_a = C_P_K2;
                alu_b = p_reg;
                ctl.op = ALU_MUL;
                ctl.rsh = 5'd16;
                t2_next = alu_y;
                state_next = P_SUMC;
            end
            P_SUMC:
            begin
                alu_a = t1_reg;
                alu_b = t2_reg;
                t1_next = alu_y;
                state_next = P_RND;
            end
            P_RND:
            begin
                alu_a = t1_reg;
                alu_b = C_P_K3;
                ctl.rsh = 5'd4;
                t1_next = alu_y;
                state_next = P_OUT;
            end
            P_OUT:
            begin
                alu_a = p_reg;
                alu_b = t1_reg;
                emit_req = 1'b1;
                if (can_emit)
                    state_next = S_IDLE;
            end
            S_FAIL:
            begin
                emit_req = 1'b1;
                emit_status = 1'b1;
                emit_value = 32'd0;
                if (can_emit)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next  = out_valid_reg && !result.ready;
        out_value_next  = out_value_reg;
        out_kind_next   = out_kind_reg;
        out_status_next = out_status_reg;
        if (emit_req && can_emit)
        begin
            out_valid_next  = 1'b1;
            out_value_next  = emit_value;
            out_kind_next   = op_reg;
            out_status_next = emit_status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            b5_reg        <= 32'd0;
            ac12_reg      <= 32'd0;
            ac34_reg      <= 32'd0;
            ac56_reg      <= 32'd0;
            b12_reg       <= 32'd0;
            mcmd_reg      <= 32'd0;
            oss_reg       <= 2'd0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            b5_reg        <= b5_next;
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    REG_AC1_AC2: ac12_reg <= cfg.data;
                    REG_AC3_AC4: ac34_reg <= cfg.data;
                    REG_AC5_AC6: ac56_reg <= cfg.data;
                    REG_B1_B2:   b12_reg  <= cfg.data;
                    REG_MC_MD:   mcmd_reg <= cfg.data;
                    REG_OSS:     oss_reg  <= cfg.data[1:0];
                    default:     ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        raw_reg        <= raw_next;
        neg_reg        <= neg_next;
        x1_reg         <= x1_next;
        t1_reg         <= t1_next;
        t2_reg         <= t2_next;
        b6_reg         <= b6_next;
        sq_reg         <= sq_next;
        b3_reg         <= b3_next;
        b4_reg         <= b4_next;
        b7_reg         <= b7_next;
        p_reg          <= p_next;
        out_value_reg  <= out_value_next;
        out_kind_reg   <= out_kind_next;
        out_status_reg <= out_status_next;
    end

    assign result.valid  = out_valid_reg;
    assign result.value  = out_value_reg;
    assign result.kind   = out_kind_reg;
    assign result.status = out_status_reg;

endmodule

[sv/bpc_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the compensation top level, attached by bind.
// Depends on bpc_pkg and on the top level's channel interfaces.
module bpc_checker
    import bpc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_value,
    input logic        out_status
);

    // one item in flight: no second beat right after an accepted one
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("sample accepted while an item is in work");

    // a result never appears in the cycle after a sample beat
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result produced too early");

    // divisor-zero status forces a zero value
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_status |-> out_value == 32'd0)
        else $error("status set with nonzero value");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_value))
        else $error("stalled result changed");

endmodule

bind barometric_pressure_compensation_top bpc_checker u_bpc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (sample.valid),
    .in_ready   (sample.ready),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .out_value  (result.value),
    .out_status (result.status)
);
